/* rtl/core/blp_pkg.sv */
// Shared types, codes and helpers for the block pool allocator.
`timescale 1ns / 1ps

package blp_pkg;

	localparam int POOL_SLOTS = 32;
	localparam logic [5:0] MAX_SLOTS = 6'd32;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
	localparam logic [1:0] ST_NO_FREE = 2'd2;
	localparam logic [1:0] ST_BAD_RELEASE = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [31:0] request_size;
		logic [4:0]  release_slot;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  granted_slot;
		logic        was_reused;
		logic [31:0] slot_bytes;
		logic [36:0] total_bytes;
		logic [1:0]  status;
	} out_word_t;

	typedef struct packed {
		logic       accept;
		logic       scan_start;
		logic       scan_run;
		logic       miss_rd;
		logic       miss_commit;
		logic       reuse_commit;
		logic       release_commit;
		logic       finish;
		logic [1:0] status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_release;
		logic req_zero;
		logic count_zero;
		logic rel_bad;
		logic hit;
		logic scan_done;
		logic round_done;
	} dp_stat_t;

	// A count of zero means one slot; anything above the pool depth is clamped.
	function automatic logic [5:0] active_count(input logic [5:0] v);
		logic [5:0] n;
		n = v;
		if (n == 6'd0) begin
			n = 6'd1;
		end
		if (n > MAX_SLOTS) begin
			n = MAX_SLOTS;
		end
		return n;
	endfunction

endpackage

/* rtl/core/blp_round.sv */
// Line rounding unit: rounds a request up to a whole number of lines by reciprocal multiplication.
`timescale 1ns / 1ps

module blp_round import blp_pkg::*; #(
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] req,
	output logic        done,
	output logic [31:0] rounded
);

	// For any 33-bit x, (x * RECIP) >> SHIFT is exactly x divided by LINE_BYTES.
	localparam int L2 = $clog2(LINE_BYTES);
	localparam int SHIFT = 33 + L2;
	localparam logic [63:0] RECIP_W =
		((64'd1 << SHIFT) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES);
	localparam logic [33:0] RECIP = RECIP_W[33:0];
	localparam logic [12:0] LINE_K = 13'(LINE_BYTES);
	localparam logic [32:0] LINE_M1 = 33'(LINE_BYTES - 1);

	localparam logic [2:0] STEP_LO_LO = 3'd5;
	localparam logic [2:0] STEP_LO_HI = 3'd4;
	localparam logic [2:0] STEP_HI_LO = 3'd3;
	localparam logic [2:0] STEP_HI_HI = 3'd2;
	localparam logic [2:0] STEP_ROUND = 3'd1;
	localparam logic [2:0] STEP_DONE = 3'd0;

	logic [32:0] x_q;
	logic [66:0] acc_q;
	logic [2:0]  step_q;
	logic [31:0] rounded_q;
	logic [16:0] op_a;
	logic [16:0] op_b;
	logic [5:0]  op_sh;
	logic [33:0] pp;
	logic [66:0] pp_sh;
	logic [32:0] quot;
	logic [45:0] prod;

	// The 33 by 34 bit product is built from four 17 by 17 bit partial products.
	always_comb begin
		case (step_q)
			STEP_LO_LO: begin
				op_a = x_q[16:0];
				op_b = RECIP[16:0];
				op_sh = 6'd0;
			end
			STEP_LO_HI: begin
				op_a = x_q[16:0];
				op_b = RECIP[33:17];
				op_sh = 6'd17;
			end
			STEP_HI_LO: begin
				op_a = {1'b0, x_q[32:17]};
				op_b = RECIP[16:0];
				op_sh = 6'd17;
			end
			STEP_HI_HI: begin
				op_a = {1'b0, x_q[32:17]};
				op_b = RECIP[33:17];
				op_sh = 6'd34;
			end
			default: begin
				op_a = '0;
				op_b = '0;
				op_sh = 6'd0;
			end
		endcase
	end

	assign pp = 34'(op_a) * 34'(op_b);
	assign pp_sh = 67'(pp) << op_sh;
	assign quot = 33'(acc_q >> SHIFT);
	assign prod = 46'(quot) * 46'(LINE_K);
	assign done = (step_q == STEP_DONE);
	assign rounded = rounded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_DONE;
		end else if (start) begin
			step_q <= STEP_LO_LO;
		end else if (step_q != STEP_DONE) begin
			step_q <= step_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= {1'b0, req} + LINE_M1;
			acc_q <= '0;
		end else if (step_q == STEP_ROUND) begin
			// The rounded value can exceed 32 bits only near the top of the range.
			rounded_q <= prod[32] ? 32'hFFFF_FFFF : prod[31:0];
		end else if (step_q != STEP_DONE) begin
			acc_q <= acc_q + pp_sh;
		end
	end

endmodule

/* rtl/core/blp_ctrl.sv */
// Sequencing state machine of the block pool allocator.
`timescale 1ns / 1ps

module blp_ctrl import blp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_stat_t  stat,
	output logic      busy,
	output ctrl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_DECIDE  = 5'b00010,
		S_SCAN    = 5'b00100,
		S_MISS_RD = 5'b01000,
		S_MISS_WR = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				cmd.finish = 1'b1;
				if (stat.is_release) begin
					if (stat.rel_bad) begin
						cmd.status = ST_BAD_RELEASE;
					end else begin
						cmd.release_commit = 1'b1;
					end
				end else if (stat.req_zero) begin
					cmd.status = ST_ZERO_SIZE;
				end else if (stat.count_zero) begin
					cmd.status = ST_NO_FREE;
				end else begin
					cmd.finish = 1'b0;
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.hit) begin
					cmd.reuse_commit = 1'b1;
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else if (stat.scan_done) begin
					state_d = S_MISS_RD;
				end
			end
			S_MISS_RD: begin
				cmd.miss_rd = 1'b1;
				if (stat.round_done) begin
					state_d = S_MISS_WR;
				end
			end
			S_MISS_WR: begin
				cmd.miss_commit = 1'b1;
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/blp_dp.sv */
// Pool datapath: size memory, free list, busy marks, running total and result register.
`timescale 1ns / 1ps

module blp_dp import blp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_data,
	input  in_word_t    item,
	input  ctrl_cmd_t   cmd,
	input  logic [31:0] rounded,
	input  logic        round_done,
	output dp_stat_t    stat,
	output logic        done,
	output out_word_t   result
);

	logic [31:0] size_mem [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] valid_q;
	logic [POOL_SLOTS-1:0] busy_q;
	logic [4:0]  free_q [POOL_SLOTS];
	logic [5:0]  count_q;
	logic [5:0]  n_q;
	logic [36:0] total_q;
	in_word_t    item_q;

	logic [5:0]  scan_idx_q;
	logic        cmp_v_s1;
	logic [4:0]  cmp_idx_s1;
	logic [31:0] rd_data_q;
	logic        rd_vld_q;

	logic        done_q;
	out_word_t   result_q;

	logic [4:0]  rd_addr;
	logic [31:0] rd_size;
	logic [36:0] total_next;
	logic [5:0]  n_new;
	logic [POOL_SLOTS-1:0] match;
	logic [POOL_SLOTS-1:0] after;

	assign n_new = active_count(cfg_data);
	assign rd_addr = cmd.miss_rd ? free_q[0] : scan_idx_q[4:0];
	assign rd_size = rd_vld_q ? rd_data_q : 32'd0;
	assign total_next = total_q - {5'd0, rd_size} + {5'd0, rounded};

	assign stat.is_release = (item_q.kind == KIND_RELEASE);
	assign stat.req_zero = (item_q.request_size == 32'd0);
	assign stat.count_zero = (count_q == 6'd0);
	assign stat.rel_bad = ({1'b0, item_q.release_slot} >= n_q) || !busy_q[item_q.release_slot];
	assign stat.hit = cmp_v_s1 && !busy_q[cmp_idx_s1] && (rd_size >= item_q.request_size);
	assign stat.scan_done = !cmp_v_s1 && (scan_idx_q >= n_q);
	assign stat.round_done = round_done;

	// Find where the reused slot sits in the free list; everything from there on moves down.
	always_comb begin
		for (int j = 0; j < POOL_SLOTS; j++) begin
			match[j] = (free_q[j] == cmp_idx_s1) && (6'(j) < count_q);
		end
		after = match;
		after = after | (after << 1);
		after = after | (after << 2);
		after = after | (after << 4);
		after = after | (after << 8);
		after = after | (after << 16);
	end

	always_ff @(posedge clk) begin
		if (cmd.miss_commit) begin
			size_mem[free_q[0]] <= rounded;
		end
		rd_data_q <= size_mem[rd_addr];
		rd_vld_q <= valid_q[rd_addr];
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.scan_start) begin
			cmp_idx_s1 <= '0;
		end else if (cmd.scan_run) begin
			cmp_idx_s1 <= scan_idx_q[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_idx_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			cmp_v_s1 <= (scan_idx_q < n_q);
			if (scan_idx_q < n_q) begin
				scan_idx_q <= scan_idx_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			busy_q <= '0;
			count_q <= MAX_SLOTS;
			n_q <= MAX_SLOTS;
			total_q <= '0;
			for (int i = 0; i < POOL_SLOTS; i++) begin
				free_q[i] <= 5'(POOL_SLOTS - 1 - i);
			end
		end else if (cfg_we) begin
			valid_q <= '0;
			busy_q <= '0;
			count_q <= n_new;
			n_q <= n_new;
			total_q <= '0;
			for (int i = 0; i < POOL_SLOTS; i++) begin
				free_q[i] <= (6'(i) < n_new) ? 5'(n_new - 6'd1 - 6'(i)) : 5'd0;
			end
		end else if (cmd.miss_commit) begin
			valid_q[free_q[0]] <= 1'b1;
			busy_q[free_q[0]] <= 1'b1;
			count_q <= count_q - 6'd1;
			total_q <= total_next;
			for (int k = 0; k < POOL_SLOTS - 1; k++) begin
				free_q[k] <= free_q[k+1];
			end
		end else if (cmd.reuse_commit) begin
			busy_q[cmp_idx_s1] <= 1'b1;
			count_q <= count_q - 6'd1;
			for (int k = 0; k < POOL_SLOTS - 1; k++) begin
				if (after[k]) begin
					free_q[k] <= free_q[k+1];
				end
			end
		end else if (cmd.release_commit) begin
			busy_q[item_q.release_slot] <= 1'b0;
			count_q <= count_q + 6'd1;
			free_q[0] <= item_q.release_slot;
			for (int k = 1; k < POOL_SLOTS; k++) begin
				free_q[k] <= free_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.status <= cmd.status;
			if (cmd.reuse_commit) begin
				result_q.granted_slot <= cmp_idx_s1;
				result_q.was_reused <= 1'b1;
				result_q.slot_bytes <= rd_size;
				result_q.total_bytes <= total_q;
			end else if (cmd.miss_commit) begin
				result_q.granted_slot <= free_q[0];
				result_q.was_reused <= 1'b0;
				result_q.slot_bytes <= rounded;
				result_q.total_bytes <= total_next;
			end else begin
				result_q.granted_slot <= '0;
				result_q.was_reused <= 1'b0;
				result_q.slot_bytes <= '0;
				result_q.total_bytes <= total_q;
			end
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

/* rtl/core/block_pool_allocator.sv */
// Top level of the first-fit block pool allocator.
//
//  channel   signals                  handshake
//  request   start, busy, item        taken at an edge with start high and busy low
//  result    done, result             valid for the one cycle that done is high
//  config    cfg_we, cfg_data         written at an edge with cfg_we high
//
// A release or any error is decided in the decide state and its result is then registered. A reuse
// scans the active slots through the size memory's single read port, one slot a cycle,
// and answers with the first free slot that fits. A resize scans every active slot,
// then writes the size from the rounding unit once that unit is done. Reset and a
// configuration write reinitialise the pool. The receiver cannot stall: each result
// word is shown once, for one cycle.
`timescale 1ns / 1ps

module block_pool_allocator import blp_pkg::*; #(
	parameter int LINE_BYTES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  item,
	output logic      done,
	output out_word_t result,
	input  logic      cfg_we,
	input  logic [5:0] cfg_data
);

	ctrl_cmd_t   cmd;
	dp_stat_t    stat;
	logic        round_done;
	logic [31:0] rounded;

	blp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	blp_round #(
		.LINE_BYTES (LINE_BYTES)
	) u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.accept),
		.req     (item.request_size),
		.done    (round_done),
		.rounded (rounded)
	);

	blp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.item       (item),
		.cmd        (cmd),
		.rounded    (rounded),
		.round_done (round_done),
		.stat       (stat),
		.done       (done),
		.result     (result)
	);

endmodule

/* bench/tb_block_pool_allocator.sv */
// Self-checking testbench for the block pool allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_block_pool_allocator;
	import blp_pkg::*;

	localparam int LINE_BYTES = 64;
	localparam int PHASE_WORDS = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_word_t   item = '0;
	logic       done;
	out_word_t  result;
	logic       cfg_we = 1'b0;
	logic [5:0] cfg_data = '0;

	always #5 clk = ~clk;

	block_pool_allocator #(
		.LINE_BYTES(LINE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the pool, updated as each word is accepted.
	logic [5:0]  shadow_count;
	logic [31:0] shadow_size [POOL_SLOTS];
	logic [4:0]  shadow_free [POOL_SLOTS];
	logic [5:0]  shadow_free_len;
	logic        shadow_busy [POOL_SLOTS];
	logic [36:0] shadow_total;

	out_word_t expected_grants[$];
	int        mismatch_count = 0;

	typedef struct {
		logic       is_cfg;
		logic [5:0] cfg_val;
		in_word_t   w;
		logic       typed;
		out_word_t  want;
	} plan_row_t;

	plan_row_t plan[$];

	function automatic int unsigned live_slots();
		int unsigned n;
		n = shadow_count;
		if (n == 0) begin
			n = 1;
		end
		if (n > POOL_SLOTS) begin
			n = POOL_SLOTS;
		end
		return n;
	endfunction

	function automatic void pool_clear();
		int unsigned n;
		n = live_slots();
		for (int i = 0; i < POOL_SLOTS; i++) begin
			shadow_size[i] = '0;
			shadow_busy[i] = 1'b0;
			shadow_free[i] = '0;
		end
		for (int unsigned i = 0; i < n; i++) begin
			shadow_free[i] = 5'(n - 1 - i);
		end
		shadow_free_len = 6'(n);
		shadow_total = '0;
	endfunction

	function automatic void free_drop(int unsigned pos);
		for (int unsigned k = pos; k + 1 < shadow_free_len; k++) begin
			shadow_free[k] = shadow_free[k + 1];
		end
		shadow_free_len = shadow_free_len - 6'd1;
	endfunction

	function automatic void free_push(logic [4:0] s);
		for (int k = shadow_free_len; k > 0; k--) begin
			if (k < POOL_SLOTS) begin
				shadow_free[k] = shadow_free[k - 1];
			end
		end
		shadow_free[0] = s;
		shadow_free_len = shadow_free_len + 6'd1;
	endfunction

	// Rounds up to a whole number of lines; anything past 32 bits saturates.
	function automatic logic [31:0] line_round(logic [31:0] req);
		logic [39:0] r;
		r = ((40'(req) + 40'(LINE_BYTES) - 40'd1) / 40'(LINE_BYTES)) * 40'(LINE_BYTES);
		if (r > 40'hFF_FFFF_FFFF >> 8) begin
			r = 40'h00_FFFF_FFFF;
		end
		return r[31:0];
	endfunction

	function automatic out_word_t grant_outcome(in_word_t w);
		out_word_t   o;
		int unsigned n;
		logic        found;
		logic [4:0]  idx;
		o = '0;
		n = live_slots();
		found = 1'b0;
		if (w.kind == KIND_ALLOC) begin
			if (w.request_size == 32'd0) begin
				o.status = ST_ZERO_SIZE;
			end else if (shadow_free_len == 6'd0) begin
				o.status = ST_NO_FREE;
			end else begin
				// First fit by slot index, not by position in the free list.
				for (int unsigned i = 0; i < n && !found; i++) begin
					if (!shadow_busy[i] && shadow_size[i] >= w.request_size) begin
						for (int unsigned j = 0; j < shadow_free_len && !found; j++) begin
							if (shadow_free[j] == 5'(i)) begin
								free_drop(j);
								found = 1'b1;
								o.granted_slot = 5'(i);
								o.was_reused = 1'b1;
							end
						end
					end
				end
				if (!found) begin
					idx = shadow_free[0];
					free_drop(0);
					shadow_total = shadow_total - 37'(shadow_size[idx]);
					shadow_size[idx] = line_round(w.request_size);
					shadow_total = shadow_total + 37'(shadow_size[idx]);
					o.granted_slot = idx;
				end
				shadow_busy[o.granted_slot] = 1'b1;
				o.slot_bytes = shadow_size[o.granted_slot];
				o.status = ST_OK;
			end
		end else begin
			if (w.release_slot >= n || !shadow_busy[w.release_slot]) begin
				o.status = ST_BAD_RELEASE;
			end else begin
				shadow_busy[w.release_slot] = 1'b0;
				free_push(w.release_slot);
				o.status = ST_OK;
			end
		end
		o.total_bytes = shadow_total;
		return o;
	endfunction

	// Mostly well-formed traffic: releases of slots that are held and allocations of
	// assorted sizes, with a little noise mixed in.
	function automatic in_word_t make_traffic_word();
		in_word_t    w;
		int unsigned n;
		int unsigned roll;
		int unsigned cls;
		logic [4:0]  held[$];
		n = live_slots();
		for (int unsigned i = 0; i < n; i++) begin
			if (shadow_busy[i]) begin
				held.push_back(5'(i));
			end
		end
		w.kind = KIND_ALLOC;
		w.request_size = $urandom;
		w.release_slot = 5'($urandom_range(0, 31));
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			w.kind = 1'($urandom_range(0, 1));
		end else if ($urandom_range(0, n) < held.size()) begin
			w.kind = KIND_RELEASE;
			w.release_slot = held[$urandom_range(0, held.size() - 1)];
		end else begin
			cls = $urandom_range(0, 99);
			if (cls < 3) begin
				w.request_size = 32'd0;
			end else if (cls < 45) begin
				w.request_size = $urandom_range(1, 256);
			end else if (cls < 75) begin
				w.request_size = $urandom_range(1, 4096);
			end else if (cls < 93) begin
				w.request_size = $urandom >> $urandom_range(0, 31);
			end else begin
				w.request_size = 32'hFFFF_FFFF - $urandom_range(0, 127);
			end
		end
		return w;
	endfunction

	function automatic void plan_word(logic k, logic [31:0] sz, logic [4:0] sl, logic typed,
			out_word_t want);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.cfg_val = '0;
		r.w.kind = k;
		r.w.request_size = sz;
		r.w.release_slot = sl;
		r.typed = typed;
		r.want = want;
		plan.push_back(r);
	endfunction

	function automatic void plan_cfg(logic [5:0] v);
		plan_row_t r;
		r.is_cfg = 1'b1;
		r.cfg_val = v;
		r.w = '0;
		r.typed = 1'b0;
		r.want = '0;
		plan.push_back(r);
	endfunction

	task automatic flag_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Holds start for a word until the block takes it, then records the expected result.
	task automatic send_word(in_word_t w, int unsigned gap, logic typed, out_word_t want);
		out_word_t predicted;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		predicted = grant_outcome(w);
		expected_grants.push_back(typed ? want : predicted);
	endtask

	task automatic write_pool_count(logic [5:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (expected_grants.size() != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		shadow_count = v;
		pool_clear();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && done) begin
			if (expected_grants.size() == 0) begin
				flag_mismatch($sformatf("result %h with nothing pending", result));
			end else begin
				want = expected_grants[0];
				expected_grants.delete(0);
				if (result.granted_slot !== want.granted_slot) begin
					flag_mismatch($sformatf("granted_slot %0d, want %0d",
						result.granted_slot, want.granted_slot));
				end
				if (result.was_reused !== want.was_reused) begin
					flag_mismatch($sformatf("was_reused %b, want %b",
						result.was_reused, want.was_reused));
				end
				if (result.slot_bytes !== want.slot_bytes) begin
					flag_mismatch($sformatf("slot_bytes %h, want %h",
						result.slot_bytes, want.slot_bytes));
				end
				if (result.total_bytes !== want.total_bytes) begin
					flag_mismatch($sformatf("total_bytes %h, want %h",
						result.total_bytes, want.total_bytes));
				end
				if (result.status !== want.status) begin
					flag_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [5:0]  phase_cfg[$];
		logic        burst;
		int unsigned gap;

		// Directed table, starting from the reset count of 32 slots.
		plan_word(KIND_ALLOC, 32'd0, 5'd0, 1'b1, '{5'd0, 1'b0, 32'd0, 37'd0, ST_ZERO_SIZE});
		plan_word(KIND_RELEASE, 32'd0, 5'd0, 1'b1, '{5'd0, 1'b0, 32'd0, 37'd0, ST_BAD_RELEASE});
		plan_word(KIND_RELEASE, 32'd0, 5'd31, 1'b1,
			'{5'd0, 1'b0, 32'd0, 37'd0, ST_BAD_RELEASE});
		plan_word(KIND_ALLOC, 32'd1, 5'd0, 1'b1, '{5'd31, 1'b0, 32'd64, 37'd64, ST_OK});
		// Rounding past the top of the size range saturates.
		plan_word(KIND_ALLOC, 32'hFFFF_FFFF, 5'd31, 1'b1,
			'{5'd30, 1'b0, 32'hFFFF_FFFF, 37'h1_0000_003F, ST_OK});
		plan_word(KIND_RELEASE, 32'hFFFF_FFFF, 5'd31, 1'b1,
			'{5'd0, 1'b0, 32'd0, 37'h1_0000_003F, ST_OK});
		plan_word(KIND_ALLOC, 32'd64, 5'd0, 1'b1,
			'{5'd31, 1'b1, 32'd64, 37'h1_0000_003F, ST_OK});
		plan_word(KIND_RELEASE, 32'd0, 5'd30, 1'b0, '0);
		plan_word(KIND_ALLOC, 32'h8000_0000, 5'd0, 1'b0, '0);
		plan_word(KIND_ALLOC, 32'hFFFF_FFC1, 5'd0, 1'b0, '0);
		plan_word(KIND_ALLOC, 32'd65, 5'd0, 1'b0, '0);
		plan_word(KIND_RELEASE, 32'd0, 5'd29, 1'b0, '0);
		plan_word(KIND_RELEASE, 32'd0, 5'd29, 1'b0, '0);
		plan_word(KIND_ALLOC, 32'd100, 5'd0, 1'b0, '0);
		// A single slot: the free list empties after one allocation.
		plan_cfg(6'd1);
		plan_word(KIND_ALLOC, 32'd5, 5'd0, 1'b1, '{5'd0, 1'b0, 32'd64, 37'd64, ST_OK});
		plan_word(KIND_ALLOC, 32'd5, 5'd0, 1'b1, '{5'd0, 1'b0, 32'd0, 37'd64, ST_NO_FREE});
		plan_word(KIND_RELEASE, 32'd0, 5'd1, 1'b1,
			'{5'd0, 1'b0, 32'd0, 37'd64, ST_BAD_RELEASE});
		plan_word(KIND_RELEASE, 32'd0, 5'd0, 1'b1, '{5'd0, 1'b0, 32'd0, 37'd64, ST_OK});
		plan_word(KIND_ALLOC, 32'd3, 5'd0, 1'b1, '{5'd0, 1'b1, 32'd64, 37'd64, ST_OK});
		// A count of zero behaves as one, and the write clears the pool.
		plan_cfg(6'd0);
		plan_word(KIND_RELEASE, 32'd0, 5'd0, 1'b1, '{5'd0, 1'b0, 32'd0, 37'd0, ST_BAD_RELEASE});
		plan_word(KIND_ALLOC, 32'd7, 5'd0, 1'b1, '{5'd0, 1'b0, 32'd64, 37'd64, ST_OK});
		// Counts above the pool depth are clamped.
		plan_cfg(6'd63);
		plan_word(KIND_RELEASE, 32'd0, 5'd31, 1'b1,
			'{5'd0, 1'b0, 32'd0, 37'd0, ST_BAD_RELEASE});
		plan_word(KIND_ALLOC, 32'd4096, 5'd0, 1'b1, '{5'd31, 1'b0, 32'd4096, 37'd4096, ST_OK});

		phase_cfg = '{6'd32, 6'd1, 6'd2, 6'd5, 6'd17, 6'd31, 6'd0, 6'd63, 6'd32,
			6'($urandom_range(0, 63))};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		shadow_count = 6'd32;
		pool_clear();
		repeat (3) @(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_pool_count(plan[i].cfg_val);
			end else begin
				send_word(plan[i].w, $urandom_range(0, 19), plan[i].typed, plan[i].want);
			end
		end

		foreach (phase_cfg[p]) begin
			write_pool_count(phase_cfg[p]);
			// Some phases run back to back with no gaps between words.
			burst = ($urandom_range(0, 3) == 0);
			repeat (PHASE_WORDS) begin
				gap = burst ? 0 : $urandom_range(0, 19);
				send_word(make_traffic_word(), gap, 1'b0, '0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (expected_grants.size() != 0) begin
			@(negedge clk);
		end
		repeat (50) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
